/* sv/mmce_pkg.sv */
// Shared constants, types and the row mapping table for the min/max column envelope unit.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package mmce_pkg;

  // Block limits and fixed field widths
  localparam int MaxSamples = 16384;
  localparam int MaxColumns = 512;
  localparam int ValueRange = 250;

  localparam int SampleW    = 8;
  localparam int SampleIdxW = $clog2(MaxSamples + 1);
  localparam int ColIdxW    = $clog2(MaxColumns);
  localparam int ColCntW    = $clog2(MaxColumns + 1);
  localparam int AccW       = $clog2(MaxColumns * MaxSamples + 1);
  localparam int DivCntW    = $clog2(AccW);

  // Configuration port
  localparam int CfgNW    = 15;
  localparam int CfgWW    = 10;
  localparam int CfgDataW = 15;
  localparam int CfgIdxW  = 1;

  localparam logic [CfgIdxW-1:0] RegSamplesPerFrame = 1'b0;
  localparam logic [CfgIdxW-1:0] RegColumnCount     = 1'b1;

  localparam logic [CfgNW-1:0] ResetSamples = CfgNW'(1024);
  localparam logic [CfgWW-1:0] ResetColumns = CfgWW'(280);

  // Row mapping: row = clamp(floor(17 - 17*v/R + 1/2), 0, 16)
  localparam int RowW     = 5;
  localparam int RowMax   = 16;
  localparam int RowScale = 17;
  localparam int RowDiv   = 2 * ValueRange;

  localparam int OutDataW = ((ColIdxW + 2 * RowW + 7) / 8) * 8;

  // Queue between front and back
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  // One finished column, raw (unbridged) extremes
  typedef struct packed {
    logic [ColIdxW-1:0] column;
    logic [SampleW-1:0] max_val;
    logic [SampleW-1:0] min_val;
    logic               last;
  } col_rec_t;

  function automatic logic [RowW-1:0] value_to_row(input logic [SampleW-1:0] v);
    int num;
    int row;
    num = (2 * RowScale + 1) * ValueRange - 2 * RowScale * int'(v);
    if (num < 0) begin
      row = 0;
    end else begin
      row = num / RowDiv;
      if (row > RowMax) begin
        row = RowMax;
      end
    end
    return RowW'(row);
  endfunction

endpackage

`default_nettype wire

/* sv/mmce_div.sv */
// Iterative restoring divider, one quotient bit per cycle, AccW steps per division.
// Depends on mmce_pkg for widths.
`default_nettype none

module mmce_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [mmce_pkg::AccW-1:0]     dividend_i,
  input  wire logic [mmce_pkg::ColCntW-1:0]  divisor_i,
  output logic                               done_o,
  output logic [mmce_pkg::AccW-1:0]          quot_o,
  output logic [mmce_pkg::ColCntW-1:0]       rem_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [mmce_pkg::DivCntW-1:0]  step_q;
  logic [mmce_pkg::AccW-1:0]     quot_q;
  logic [mmce_pkg::ColCntW-1:0]  rem_q;
  logic [mmce_pkg::ColCntW-1:0]  dvs_q;

  logic [mmce_pkg::ColCntW:0]    trial;
  logic                          fits;

  always_comb begin
    trial = {rem_q, quot_q[mmce_pkg::AccW-1]};
    fits  = trial >= {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (busy_q) begin
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - 1'b1;
        end
      end else if (start_i) begin
        busy_q <= 1'b1;
        step_q <= mmce_pkg::DivCntW'(mmce_pkg::AccW - 1);
      end
    end
  end

  // Shift the dividend out of the top of quot_q while quotient bits enter below
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      rem_q  <= fits ? mmce_pkg::ColCntW'(trial - {1'b0, dvs_q})
                     : trial[mmce_pkg::ColCntW-1:0];
      quot_q <= {quot_q[mmce_pkg::AccW-2:0], fits};
    end else if (start_i) begin
      rem_q  <= '0;
      quot_q <= dividend_i;
      dvs_q  <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

/* sv/mmce_front.sv */
// Front end: configuration registers, span recompute sequencer, sample tracking and
// column close detection. Depends on mmce_pkg and mmce_div.
`default_nettype none

module mmce_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [mmce_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [mmce_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire logic                            s_valid_i,
  output logic                                 s_ready_o,
  input  wire logic [mmce_pkg::SampleW-1:0]    sample_i,
  input  wire logic                            frame_start_i,
  input  wire logic                            fifo_full_i,
  output logic                                 rec_push_o,
  output mmce_pkg::col_rec_t                   rec_o
);

  localparam logic [1:0] StRun      = 2'd0;
  localparam logic [1:0] StDivSpan  = 2'd1;
  localparam logic [1:0] StDivStart = 2'd2;

  localparam int SIW = mmce_pkg::SampleIdxW;
  localparam int CCW = mmce_pkg::ColCntW;
  localparam int AW  = mmce_pkg::AccW;
  localparam int SW  = mmce_pkg::SampleW;

  // Configuration and sequencer
  logic [mmce_pkg::CfgNW-1:0] samples_q;
  logic [mmce_pkg::CfgWW-1:0] columns_q;
  logic                       pending_q;
  logic [1:0]                 state_q;

  // Column geometry: span = n/w, start = acc/w with fractional remainder
  logic [SIW-1:0] q_q;
  logic [CCW-1:0] r_q;
  logic [AW-1:0]  start_q;
  logic [CCW-1:0] rem_q;
  logic [AW-1:0]  acc_q;

  // Sample tracking
  logic [SIW-1:0] idx_q;
  logic [CCW-1:0] col_q;
  logic [SIW-1:0] cnt_q;
  logic           open_q;
  logic [SW-1:0]  min_q;
  logic [SW-1:0]  max_q;

  logic [SIW-1:0] n_eff;
  logic [CCW-1:0] w_cap;
  logic [CCW-1:0] w_eff;

  logic           div_start;
  logic [AW-1:0]  div_dividend;
  logic           div_done;
  logic [AW-1:0]  div_quot;
  logic [CCW-1:0] div_rem;

  logic [SIW-1:0] idx_v;
  logic [CCW-1:0] col_v;
  logic [AW-1:0]  acc_v;
  logic [AW-1:0]  start_v;
  logic [CCW-1:0] rem_v;
  logic [SIW-1:0] cnt_v;
  logic           open_v;
  logic [SW-1:0]  min_v;
  logic [SW-1:0]  max_v;

  logic [SIW-1:0] idx_d;
  logic [CCW-1:0] col_d;
  logic [AW-1:0]  acc_d;
  logic [AW-1:0]  start_d;
  logic [CCW-1:0] rem_d;
  logic [SIW-1:0] cnt_d;
  logic           open_d;
  logic [SW-1:0]  min_d;
  logic [SW-1:0]  max_d;

  logic           active;
  logic           hit;
  logic           close;
  logic [CCW:0]   rem_sum;
  logic           carry;
  logic [CCW-1:0] col_inc;
  logic           accept;

  // Effective configuration: clamp n, then w against the column limit and n
  always_comb begin
    n_eff = (samples_q > SIW'(mmce_pkg::MaxSamples)) ? SIW'(mmce_pkg::MaxSamples)
                                                      : SIW'(samples_q);
    w_cap = (columns_q > mmce_pkg::CfgWW'(mmce_pkg::MaxColumns))
            ? CCW'(mmce_pkg::MaxColumns) : CCW'(columns_q);
    w_eff = (SIW'(w_cap) > n_eff) ? n_eff[CCW-1:0] : w_cap;
  end

  assign s_ready_o = (state_q == StRun) && !pending_q && !fifo_full_i;
  assign accept    = s_valid_i && s_ready_o;

  assign div_start    = ((state_q == StRun) && pending_q && (w_eff != '0)) ||
                        ((state_q == StDivSpan) && div_done);
  assign div_dividend = (state_q == StRun) ? AW'(n_eff) : acc_q;

  mmce_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (w_eff),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_comb begin
    idx_v   = idx_q;
    col_v   = col_q;
    acc_v   = acc_q;
    start_v = start_q;
    rem_v   = rem_q;
    cnt_v   = cnt_q;
    open_v  = open_q;
    min_v   = min_q;
    max_v   = max_q;
    // Frame mark restarts everything before this sample is looked at
    if (frame_start_i) begin
      idx_v   = '0;
      col_v   = '0;
      acc_v   = '0;
      start_v = '0;
      rem_v   = '0;
      cnt_v   = '0;
      open_v  = 1'b0;
      min_v   = '1;
      max_v   = '0;
    end

    active = (w_eff != '0) && (col_v < w_eff);
    hit    = (start_v == AW'(idx_v));

    min_d  = min_v;
    max_d  = max_v;
    cnt_d  = cnt_v;
    open_d = open_v;
    if (active) begin
      if (hit) begin
        min_d  = sample_i;
        max_d  = sample_i;
        cnt_d  = SIW'(1);
        open_d = 1'b1;
      end else if (open_v) begin
        if (sample_i < min_v) begin
          min_d = sample_i;
        end
        if (sample_i > max_v) begin
          max_d = sample_i;
        end
        cnt_d = cnt_v + 1'b1;
      end
    end

    close   = active && open_d && (cnt_d >= q_q);
    rem_sum = {1'b0, rem_v} + {1'b0, r_q};
    carry   = rem_sum >= {1'b0, w_eff};
    col_inc = col_v + 1'b1;

    col_d   = col_v;
    acc_d   = acc_v;
    start_d = start_v;
    rem_d   = rem_v;
    if (close) begin
      // Advance to the next column start: start += n/w with remainder carry
      col_d   = col_inc;
      acc_d   = acc_v + AW'(n_eff);
      rem_d   = carry ? CCW'(rem_sum - {1'b0, w_eff}) : rem_sum[CCW-1:0];
      start_d = start_v + AW'(q_q) + AW'(carry);
      cnt_d   = '0;
      open_d  = 1'b0;
    end

    idx_d = (idx_v < SIW'(mmce_pkg::MaxSamples)) ? idx_v + 1'b1 : idx_v;

    rec_o.column  = col_v[mmce_pkg::ColIdxW-1:0];
    rec_o.max_val = max_d;
    rec_o.min_val = min_d;
    rec_o.last    = (col_inc == w_eff);
  end

  assign rec_push_o = accept && close;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samples_q <= mmce_pkg::ResetSamples;
      columns_q <= mmce_pkg::ResetColumns;
      pending_q <= 1'b1;
      state_q   <= StRun;
      q_q       <= '0;
      r_q       <= '0;
      start_q   <= '0;
      rem_q     <= '0;
      acc_q     <= '0;
      idx_q     <= '0;
      col_q     <= '0;
      cnt_q     <= '0;
      open_q    <= 1'b0;
      min_q     <= '1;
      max_q     <= '0;
    end else begin
      case (state_q)
        StRun: begin
          if (pending_q) begin
            pending_q <= 1'b0;
            if (w_eff == '0) begin
              q_q <= '0;
              r_q <= '0;
            end else begin
              state_q <= StDivSpan;
            end
          end
        end
        StDivSpan: begin
          if (div_done) begin
            q_q     <= div_quot[SIW-1:0];
            r_q     <= div_rem;
            state_q <= StDivStart;
          end
        end
        StDivStart: begin
          if (div_done) begin
            start_q <= div_quot;
            rem_q   <= div_rem;
            state_q <= StRun;
          end
        end
        default: begin
          state_q <= StRun;
        end
      endcase

      // A write during a recompute simply queues another one
      if (cfg_we_i) begin
        case (cfg_index_i)
          mmce_pkg::RegSamplesPerFrame: begin
            samples_q <= cfg_data_i[mmce_pkg::CfgNW-1:0];
            pending_q <= 1'b1;
          end
          mmce_pkg::RegColumnCount: begin
            columns_q <= cfg_data_i[mmce_pkg::CfgWW-1:0];
            pending_q <= 1'b1;
          end
          default: ;
        endcase
      end

      if (accept) begin
        idx_q   <= idx_d;
        col_q   <= col_d;
        acc_q   <= acc_d;
        start_q <= start_d;
        rem_q   <= rem_d;
        cnt_q   <= cnt_d;
        open_q  <= open_d;
        min_q   <= min_d;
        max_q   <= max_d;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/mmce_fifo.sv */
// Short queue of finished column records between the front and back ends.
// Depends on mmce_pkg for the record type and depth.
`default_nettype none

module mmce_fifo (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  mmce_pkg::col_rec_t       push_data_i,
  output logic                     full_o,
  input  wire logic                pop_i,
  output logic                     valid_o,
  output mmce_pkg::col_rec_t       data_o
);

  mmce_pkg::col_rec_t                 mem_q [mmce_pkg::FifoDepth];
  logic [mmce_pkg::FifoPtrW-1:0]      wr_ptr_q;
  logic [mmce_pkg::FifoPtrW-1:0]      rd_ptr_q;
  logic [mmce_pkg::FifoCntW-1:0]      count_q;
  logic                               do_pop;

  assign full_o  = (count_q == mmce_pkg::FifoCntW'(mmce_pkg::FifoDepth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* sv/mmce_back.sv */
// Back end: bridges each column but the first to the previous one, maps extremes to rows and
// holds the result in an output register. Depends on mmce_pkg.
`default_nettype none

module mmce_back (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           rec_valid_i,
  input  mmce_pkg::col_rec_t                  rec_i,
  output logic                                rec_pop_o,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [mmce_pkg::ColIdxW-1:0]        out_column_o,
  output logic [mmce_pkg::RowW-1:0]           out_high_row_o,
  output logic [mmce_pkg::RowW-1:0]           out_low_row_o,
  output logic                                out_last_o
);

  logic [mmce_pkg::SampleW-1:0] prev_min_q;
  logic [mmce_pkg::SampleW-1:0] prev_max_q;
  logic                         out_valid_q;
  logic [mmce_pkg::ColIdxW-1:0] column_q;
  logic [mmce_pkg::RowW-1:0]    high_row_q;
  logic [mmce_pkg::RowW-1:0]    low_row_q;
  logic                         last_q;

  logic [mmce_pkg::SampleW-1:0] hi;
  logic [mmce_pkg::SampleW-1:0] lo;
  logic                         bridge;

  assign rec_pop_o = rec_valid_i && (!out_valid_q || out_ready_i);

  // Close the gap to the previous column; the first column stands alone
  always_comb begin
    bridge = (rec_i.column != '0);
    hi     = rec_i.max_val;
    lo     = rec_i.min_val;
    if (bridge && (rec_i.max_val < prev_min_q)) begin
      hi = prev_min_q;
    end
    if (bridge && (rec_i.min_val > prev_max_q)) begin
      lo = prev_max_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      prev_min_q  <= '0;
      prev_max_q  <= '0;
    end else begin
      if (rec_pop_o) begin
        out_valid_q <= 1'b1;
        prev_min_q  <= rec_i.min_val;
        prev_max_q  <= rec_i.max_val;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_pop_o) begin
      column_q   <= rec_i.column;
      high_row_q <= mmce_pkg::value_to_row(hi);
      low_row_q  <= mmce_pkg::value_to_row(lo);
      last_q     <= rec_i.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_column_o   = column_q;
  assign out_high_row_o = high_row_q;
  assign out_low_row_o  = low_row_q;
  assign out_last_o     = last_q;

endmodule

`default_nettype wire

/* sv/minmax_column_envelope_unit.sv */
// Min/max column envelope: one sample per cycle in while s_axis_tready is high, one row pair per finished column out.
// A column's last sample reaches m_axis through the record queue and then the output register.
// After reset and after every configuration write, s_axis_tready stays low while the shared
// divider computes the column span and the current column start (for a nonzero column count).
// Reset returns the registers to 1024 samples and 280 columns and starts a new frame.
// Depends on mmce_pkg, mmce_front, mmce_div, mmce_fifo and mmce_back.
`default_nettype none

module minmax_column_envelope_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [mmce_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [mmce_pkg::CfgDataW-1:0]     cfg_data_i,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [mmce_pkg::SampleW-1:0]      s_axis_tdata,  // [7:0] sample
  input  wire logic                              s_axis_tuser,  // [0] frame_start
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [mmce_pkg::OutDataW-1:0]          m_axis_tdata,  // column, high_row, low_row
  output logic                                   m_axis_tlast
);

  logic                          rec_push;
  mmce_pkg::col_rec_t            rec_in;
  logic                          fifo_full;
  logic                          fifo_valid;
  mmce_pkg::col_rec_t            rec_out;
  logic                          rec_pop;
  logic [mmce_pkg::ColIdxW-1:0]  out_column;
  logic [mmce_pkg::RowW-1:0]     out_high_row;
  logic [mmce_pkg::RowW-1:0]     out_low_row;

  mmce_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_valid_i     (s_axis_tvalid),
    .s_ready_o     (s_axis_tready),
    .sample_i      (s_axis_tdata),
    .frame_start_i (s_axis_tuser),
    .fifo_full_i   (fifo_full),
    .rec_push_o    (rec_push),
    .rec_o         (rec_in)
  );

  mmce_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (rec_push),
    .push_data_i (rec_in),
    .full_o      (fifo_full),
    .pop_i       (rec_pop),
    .valid_o     (fifo_valid),
    .data_o      (rec_out)
  );

  mmce_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rec_valid_i    (fifo_valid),
    .rec_i          (rec_out),
    .rec_pop_o      (rec_pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_column_o   (out_column),
    .out_high_row_o (out_high_row),
    .out_low_row_o  (out_low_row),
    .out_last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = mmce_pkg::OutDataW'({out_low_row, out_high_row, out_column});

`ifndef ASSERT_OFF
  // Bridged maximum never sits below the bridged minimum on screen
  a_row_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_high_row <= out_low_row))
    else $error("high row below low row");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((out_low_row <= mmce_pkg::RowW'(mmce_pkg::RowMax)) &&
                       (out_high_row <= mmce_pkg::RowW'(mmce_pkg::RowMax))))
    else $error("row out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_push |-> !fifo_full)
    else $error("column record pushed into full queue");
`endif

endmodule

`default_nettype wire
